// ----- design/tbpp_pkg.sv -----
// Shared types and constants for the timestamp bin parity bit packer.
// No dependencies; used by the controller, datapath, top level and checker.
package tbpp_pkg;

  localparam int unsigned TS_W         = 30;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned DIV_STEPS    = TS_W;
  localparam int unsigned DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam int unsigned ZRUN_W       = 9;
  localparam int unsigned HELD_W       = $clog2(BYTE_W);
  localparam int unsigned NBIT_W       = HELD_W + 1;
  localparam int unsigned IN_TDATA_W   = 32;
  localparam logic [ZRUN_W-1:0] MAX_ZERO_RUN = 9'd503;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_DECIDE,
    ST_PARITY,
    ST_ZEROS,
    ST_FLUSH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic decide;
    logic push_parity;
    logic push_zeros;
    logic flush;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_last;
    logic need_push;
    logic parity_ok;
    logic zeros_ok;
    logic zeros_empty;
    logic held_empty;
    logic out_free;
  } sts_t;

endpackage

// ----- design/tbpp_ctrl.sv -----
// Controller FSM of the bin parity packer: sequences divide, decide, bit push and flush.
// Depends on tbpp_pkg (state_t, cmd_t, sts_t).
module tbpp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic           in_tlast,
  output logic           in_tready,
  input  tbpp_pkg::sts_t sts,
  output tbpp_pkg::cmd_t cmd
);

  tbpp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tbpp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tbpp_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = in_tlast ? tbpp_pkg::ST_FLUSH : tbpp_pkg::ST_DIVIDE;
        end
      end
      tbpp_pkg::ST_DIVIDE: begin
        if (sts.div_last) state_nxt = tbpp_pkg::ST_DECIDE;
      end
      tbpp_pkg::ST_DECIDE: begin
        state_nxt = sts.need_push ? tbpp_pkg::ST_PARITY : tbpp_pkg::ST_IDLE;
      end
      tbpp_pkg::ST_PARITY: begin
        if (sts.parity_ok) state_nxt = tbpp_pkg::ST_ZEROS;
      end
      tbpp_pkg::ST_ZEROS: begin
        if (sts.zeros_empty) state_nxt = tbpp_pkg::ST_IDLE;
      end
      tbpp_pkg::ST_FLUSH: begin
        if (sts.held_empty || sts.out_free) state_nxt = tbpp_pkg::ST_IDLE;
      end
      default: state_nxt = tbpp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      tbpp_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid && !in_tlast;
      end
      tbpp_pkg::ST_DIVIDE: cmd.div_step    = 1'b1;
      tbpp_pkg::ST_DECIDE: cmd.decide      = 1'b1;
      tbpp_pkg::ST_PARITY: cmd.push_parity = sts.parity_ok;
      tbpp_pkg::ST_ZEROS:  cmd.push_zeros  = !sts.zeros_empty && sts.zeros_ok;
      tbpp_pkg::ST_FLUSH:  cmd.flush       = !sts.held_empty && sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- design/tbpp_dp.sv -----
// Datapath of the bin parity packer: bin width register, restoring divider,
// bin tracking, bit packer and output word register. Depends on tbpp_pkg.
module tbpp_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [tbpp_pkg::TS_W-1:0]     cfg_wr_data,
  input  logic [tbpp_pkg::TS_W-1:0]     in_ts,
  input  tbpp_pkg::cmd_t                cmd,
  output tbpp_pkg::sts_t                sts,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [tbpp_pkg::BYTE_W-1:0]   out_byte,
  output logic                          out_last,
  output logic                          out_clip
);

  localparam int unsigned W  = tbpp_pkg::TS_W;
  localparam int unsigned B  = tbpp_pkg::BYTE_W;
  localparam int unsigned HW = tbpp_pkg::HELD_W;
  localparam int unsigned NW = tbpp_pkg::NBIT_W;
  localparam int unsigned ZW = tbpp_pkg::ZRUN_W;

  logic [W-1:0]  bin_width_r;
  logic [W-1:0]  ts_r, quot_r, rem_r, base_r, cur_bin_r;
  logic [tbpp_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic          started_r, parity_r, clip_r;
  logic [B-1:0]  shreg_r;
  logic [HW-1:0] held_r;
  logic [ZW-1:0] zeros_r;
  logic          out_valid_r, out_last_r, out_clip_r;
  logic [B-1:0]  out_byte_r;

  logic [W-1:0]  w_eff, offset, dividend, gap;
  logic [W:0]    rem_sh, rem_diff;
  logic          rem_ge;
  logic          out_free;
  logic [NW-1:0] room, nbits, held_sum;
  logic [B-1:0]  zshift;
  logic [ZW-1:0] zeros_left;
  logic          zeros_emit;
  logic          out_load;

  assign w_eff    = (bin_width_r == '0) ? W'(1) : bin_width_r;
  assign offset   = (in_ts >= base_r) ? (in_ts - base_r) : '0;
  assign dividend = started_r ? offset : in_ts;

  // one quotient bit per cycle; dividend bits shift out of quot_r's top
  assign rem_sh   = {rem_r, quot_r[W-1]};
  assign rem_diff = rem_sh - {1'b0, w_eff};
  assign rem_ge   = (rem_sh >= {1'b0, w_eff});

  assign gap      = quot_r - cur_bin_r - W'(1);

  assign out_free = !out_valid_r || out_tready;

  // zero run: each push fills up to the end of the current byte
  assign room       = NW'(B) - {1'b0, held_r};
  assign nbits      = (zeros_r < {{(ZW-NW){1'b0}}, room}) ? zeros_r[NW-1:0] : room;
  assign held_sum   = {1'b0, held_r} + nbits;
  assign zshift     = shreg_r << nbits;
  assign zeros_left = zeros_r - {{(ZW-NW){1'b0}}, nbits};
  assign zeros_emit = (held_sum == NW'(B));

  // a word enters the output register this cycle
  assign out_load = (cmd.push_parity && (held_r == HW'(B - 1)))
                 || (cmd.push_zeros && zeros_emit) || cmd.flush;

  always_comb begin
    sts.div_last    = (div_cnt_r == tbpp_pkg::DIV_CNT_W'(tbpp_pkg::DIV_STEPS - 1));
    sts.need_push   = started_r && (quot_r != cur_bin_r);
    sts.parity_ok   = out_free || (held_r != HW'(B - 1));
    sts.zeros_ok    = out_free || !zeros_emit;
    sts.zeros_empty = (zeros_r == '0);
    sts.held_empty  = (held_r == '0);
    sts.out_free    = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_width_r <= W'(1);
      started_r   <= 1'b0;
      base_r      <= '0;
      cur_bin_r   <= '0;
      parity_r    <= 1'b0;
      shreg_r     <= '0;
      held_r      <= '0;
      zeros_r     <= '0;
      clip_r      <= 1'b0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) bin_width_r <= cfg_wr_data;

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (cmd.load) begin
        ts_r      <= in_ts;
        quot_r    <= dividend;
        rem_r     <= '0;
        div_cnt_r <= '0;
      end

      if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + 1'b1;
        quot_r    <= {quot_r[W-2:0], rem_ge};
        rem_r     <= rem_ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
      end

      if (cmd.decide) begin
        if (!started_r) begin
          // first event: base is the timestamp rounded down to a bin edge
          base_r    <= ts_r - rem_r;
          cur_bin_r <= '0;
          parity_r  <= 1'b1;
          started_r <= 1'b1;
        end else if (quot_r == cur_bin_r) begin
          parity_r <= !parity_r;
        end else begin
          cur_bin_r <= quot_r;
          if (quot_r > cur_bin_r) begin
            if (gap > W'(tbpp_pkg::MAX_ZERO_RUN)) begin
              zeros_r <= tbpp_pkg::MAX_ZERO_RUN;
              clip_r  <= 1'b1;
            end else begin
              zeros_r <= gap[ZW-1:0];
              clip_r  <= 1'b0;
            end
          end else begin
            zeros_r <= '0;
            clip_r  <= 1'b0;
          end
        end
      end

      if (cmd.push_parity) begin
        parity_r <= 1'b1;
        if (held_r == HW'(B - 1)) begin
          out_byte_r  <= {shreg_r[B-2:0], parity_r};
          out_last_r  <= (zeros_r < ZW'(B));
          out_clip_r  <= clip_r;
          shreg_r     <= '0;
          held_r      <= '0;
        end else begin
          shreg_r <= {shreg_r[B-2:0], parity_r};
          held_r  <= held_r + 1'b1;
        end
      end

      if (cmd.push_zeros) begin
        zeros_r <= zeros_left;
        if (zeros_emit) begin
          out_byte_r  <= zshift;
          out_last_r  <= (zeros_left < ZW'(B));
          out_clip_r  <= clip_r;
          shreg_r     <= '0;
          held_r      <= '0;
        end else begin
          shreg_r <= zshift;
          held_r  <= held_sum[HW-1:0];
        end
      end

      if (cmd.flush) begin
        out_byte_r  <= shreg_r;
        out_last_r  <= 1'b1;
        out_clip_r  <= 1'b0;
        shreg_r     <= '0;
        held_r      <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;
  assign out_clip   = out_clip_r;

endmodule

// ----- design/timestamp_bin_parity_bit_packer_top.sv -----
// Top level of the timestamp bin parity bit packer.
// Depends on tbpp_pkg, tbpp_ctrl and tbpp_dp.
//
// Items are taken one at a time. An event word is accepted, divided by the
// bin width in a restoring divide and then decided on; when it closes a bin
// the packer then pushes the parity bit and then the empty-bin zero run
// (clipped at 503 zeros), shifting in up to the rest of a byte per cycle unless stalled.
// An event that stays in its bin, or the first event, ends at the decide.
// A flush is accepted and then sends out any partly filled byte as the last.
// Output bytes wait in a one-word output register; the packer stalls only
// when it must load a new byte while that register is still full.
module timestamp_bin_parity_bit_packer_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [tbpp_pkg::TS_W-1:0]         cfg_wr_data,  // bin_width
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tbpp_pkg::IN_TDATA_W-1:0]   in_tdata,     // [29:0] timestamp, [31:30] zero
  input  logic                              in_tlast,     // end_of_stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tbpp_pkg::BYTE_W-1:0]       out_tdata,    // [7:0] packed_byte
  output logic                              out_tlast,    // last_of_run
  output logic                              out_tuser     // [0] gap_clipped
);

  tbpp_pkg::cmd_t cmd;
  tbpp_pkg::sts_t sts;

  tbpp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tbpp_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ts       (in_tdata[tbpp_pkg::TS_W-1:0]),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_byte    (out_tdata),
    .out_last    (out_tlast),
    .out_clip    (out_tuser)
  );

endmodule

// ----- design/tbpp_checker.sv -----
// Port-level checker for the bin parity packer, bound to the top level.
// Depends on tbpp_pkg and timestamp_bin_parity_bit_packer_top.
module tbpp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tbpp_pkg::BYTE_W-1:0]     out_tdata,
  input logic                            out_tlast,
  input logic                            out_tuser
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("output word changed while stalled");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in progress");

  // an event word is still busy in the last step of the divide
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast |=> ##29 !in_tready)
    else $error("event word finished before the divide completed");

  // no output word right out of reset
  a_rst_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind timestamp_bin_parity_bit_packer_top tbpp_checker u_tbpp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
